// ===== rtl/local_mean_forecast_error_trend_top_defines.svh =====
// assertion macros for the local mean forecast error trend block
`ifndef LOCAL_MEAN_FORECAST_ERROR_TREND_TOP_DEFINES_SVH
`define LOCAL_MEAN_FORECAST_ERROR_TREND_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define LMFET_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LMFET_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LMFET_ASSERT_IMPL(lbl, ante, cons, msg)
`define LMFET_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/lmfet_pkg.sv =====
// types and constants of the local mean forecast error trend block
`default_nettype none
package lmfet_pkg;
	localparam int SAMPLE_W = 32;
	localparam int RS_W = 56;
	localparam int SS_W = 64;
	localparam int DIV_W = 64;
	localparam int DCNT_W = 6;
	localparam int SQ_STEPS = 32;
	localparam int FEAT_FRAC = 30;
	localparam logic [63:0] VAR_MAX = 64'h0000_FFFF_FFFF_FFFF;

	typedef logic [1:0] status_t;
	localparam status_t STAT_OK = 2'd0;
	localparam status_t STAT_SHORT = 2'd1;
	localparam status_t STAT_FLAT = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CRD, ST_CMEAN, ST_CR, ST_CMUL, ST_CWR,
		ST_RBEG, ST_RRD, ST_RM, ST_RMSQ, ST_RP, ST_RV, ST_SQRT, ST_RSD,
		ST_RFIN, ST_RQ, ST_DONE, ST_DIV
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/local_mean_forecast_error_trend_top.sv =====
// local mean forecast error trend: top level
// Input channel in_valid/in_stall carries sample (signed Q16.16) and is_last.
// Output channel out_valid/out_stall carries feature (signed Q1.30) and status,
// one transaction per series, on the transaction whose is_last is set.
// Each sample walks the window cells 1..MAX_WINDOW through one state memory
// entry each; each cell is read, its mean formed by a shared 64-step
// restoring divider, then residual, square and write back. A sample is not
// accepted until every cell of the previous one is written back, so
// in_stall is low only between samples.
// At the end of a series each window length takes three divides on the
// shared divider and a 32-step square root, then a final ratio divide forms
// the feature unless the range of the deviations is zero.
// Samples beyond MAX_SAMPLES are not accumulated.
// A finished result sits in an output register; the next series may start
// while it waits. If a second result is ready before the first is taken, the
// block holds it and stalls input until the output register frees.
// Reset (arst_n low) empties all cell state, the sample count and the output.
// After each result is loaded, the cell state and sample count return to reset.
`default_nettype none
`include "local_mean_forecast_error_trend_top_defines.svh"
module local_mean_forecast_error_trend_top
	import lmfet_pkg::*;
#(
	parameter int MAX_WINDOW = 10,
	parameter int MAX_SAMPLES = 65536
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	input  wire logic                       is_last,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic signed [31:0]              feature,
	output status_t                         status
);
	localparam int K_W = $clog2(MAX_WINDOW);
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int WS_W = SAMPLE_W + $clog2(MAX_WINDOW);
	localparam int ENT_W = WS_W + RS_W + SS_W;

	state_t state_q, state_d, div_ret_q;
	logic [K_W-1:0] k_q;
	logic [CNT_W-1:0] seen_q;
	logic [MAX_WINDOW-1:0] vld_q;
	logic signed [SAMPLE_W-1:0] rec_q [MAX_WINDOW];
	logic signed [SAMPLE_W-1:0] y_q;
	logic last_q;

	logic [ENT_W-1:0] mem [MAX_WINDOW];
	logic [ENT_W-1:0] rd_q;
	logic rvld_q;

	logic signed [WS_W-1:0] e_ws_q;
	logic signed [RS_W-1:0] e_rs_q;
	logic [SS_W-1:0] e_ss_q;
	logic ws_neg_q;
	logic signed [33:0] r_q;
	logic [65:0] prod_q;
	logic [63:0] msq_q, p_q;
	logic [31:0] lo_q, hi_q, first_q, lastsd_q;
	logic neg_q;

	logic [DIV_W-1:0] div_rem_q, div_quo_q, div_den_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic [63:0] sq_v_q, sq_res_q, sq_bit_q;
	logic [4:0] sq_cnt_q;

	logic out_valid_q;
	logic signed [31:0] feature_q, res_feat_q;
	status_t status_q, res_stat_q;

	logic accept, can_load, cell_last, red_last;

	// memory read side
	logic signed [WS_W-1:0] rd_ws;
	logic signed [RS_W-1:0] rd_rs;
	logic [SS_W-1:0] rd_ss;
	assign rd_ws = rvld_q ? rd_q[ENT_W-1 -: WS_W] : '0;
	assign rd_rs = rvld_q ? rd_q[SS_W+RS_W-1 -: RS_W] : '0;
	assign rd_ss = rvld_q ? rd_q[SS_W-1:0] : '0;

	// divider step
	logic [DIV_W:0] dv_sh, dv_diff;
	logic dv_ge;
	logic [DIV_W-1:0] dv_rem_n;
	assign dv_sh = {div_rem_q, div_quo_q[DIV_W-1]};
	assign dv_diff = dv_sh - {1'b0, div_den_q};
	assign dv_ge = dv_sh >= {1'b0, div_den_q};
	assign dv_rem_n = dv_ge ? dv_diff[DIV_W-1:0] : dv_sh[DIV_W-1:0];

	// square root step
	logic [63:0] sq_t;
	logic sq_ge;
	assign sq_t = sq_res_q + sq_bit_q;
	assign sq_ge = sq_v_q >= sq_t;

	// cell arithmetic
	logic [32:0] c_mag;
	logic signed [32:0] c_mean;
	logic signed [33:0] c_r, c_abs;
	logic [49:0] c_sq;
	logic signed [RS_W:0] c_rs_sum;
	logic signed [RS_W-1:0] c_rs_new;
	logic [SS_W:0] c_ss_sum;
	logic [SS_W-1:0] c_ss_new;
	logic signed [WS_W-1:0] c_ws_new;
	logic [RS_W-1:0] rs_abs;
	logic c_active;
	assign c_mag = {1'b0, div_quo_q[31:0]};
	assign c_mean = ws_neg_q ? -$signed(c_mag) : $signed(c_mag);
	assign c_r = {c_mean[32], c_mean} - {{2{y_q[SAMPLE_W-1]}}, y_q};
	assign c_abs = r_q[33] ? -r_q : r_q;
	assign c_sq = prod_q[65:16];
	assign c_rs_sum = {e_rs_q[RS_W-1], e_rs_q} + {{(RS_W-33){r_q[33]}}, r_q};
	assign c_rs_new = (c_rs_sum[RS_W] != c_rs_sum[RS_W-1]) ?
		(c_rs_sum[RS_W] ? {1'b1, {(RS_W-1){1'b0}}} : {1'b0, {(RS_W-1){1'b1}}}) :
		c_rs_sum[RS_W-1:0];
	assign c_ss_sum = {1'b0, e_ss_q} + {{(SS_W+1-50){1'b0}}, c_sq};
	assign c_ss_new = c_ss_sum[SS_W] ? {SS_W{1'b1}} : c_ss_sum[SS_W-1:0];
	assign c_ws_new = e_ws_q + {{(WS_W-SAMPLE_W){y_q[SAMPLE_W-1]}}, y_q}
		- {{(WS_W-SAMPLE_W){rec_q[k_q][SAMPLE_W-1]}}, rec_q[k_q]};
	assign c_active = seen_q > CNT_W'(k_q);
	assign rs_abs = rd_rs[RS_W-1] ? RS_W'(-rd_rs) : RS_W'(rd_rs);

	// reduction arithmetic
	logic [CNT_W-1:0] n_c;
	logic [31:0] am;
	logic [63:0] am_sq, p_c, v_c, vs_c;
	logic [31:0] sd_c, range_c, mag_c;
	logic [63:0] fden_c;
	assign n_c = seen_q - CNT_W'(k_q) - CNT_W'(1);
	assign am = (div_quo_q[63:32] != '0) ? 32'hFFFF_FFFF : div_quo_q[31:0];
	assign am_sq = am * am;
	assign p_c = (div_quo_q > msq_q) ? div_quo_q - msq_q : 64'd0;
	assign v_c = p_q + div_quo_q;
	assign vs_c = (v_c > VAR_MAX) ? VAR_MAX : v_c;
	assign sd_c = sq_res_q[31:0];
	assign range_c = hi_q - lo_q;
	assign mag_c = (lastsd_q < first_q) ? first_q - lastsd_q : lastsd_q - first_q;
	assign fden_c = 64'(range_c) * 64'(MAX_WINDOW - 1);

	assign accept = in_valid && !in_stall;
	assign can_load = !out_valid_q || !out_stall;
	assign cell_last = k_q == K_W'(MAX_WINDOW - 1);
	assign red_last = cell_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (seen_q < CNT_W'(MAX_SAMPLES)) state_d = ST_CRD;
					else if (is_last) state_d = ST_RBEG;
				end
			end
			ST_CRD: state_d = ST_CMEAN;
			ST_CMEAN: state_d = ST_DIV;
			ST_CR: state_d = ST_CMUL;
			ST_CMUL: state_d = ST_CWR;
			ST_CWR: begin
				if (!cell_last) state_d = ST_CRD;
				else if (last_q) state_d = ST_RBEG;
				else state_d = ST_IDLE;
			end
			ST_RBEG: state_d = (seen_q < CNT_W'(MAX_WINDOW + 2)) ? ST_DONE : ST_RRD;
			ST_RRD: state_d = ST_RM;
			ST_RM: state_d = ST_DIV;
			ST_RMSQ: state_d = ST_DIV;
			ST_RP: state_d = ST_DIV;
			ST_RV: state_d = ST_SQRT;
			ST_SQRT: if (sq_cnt_q == 5'(SQ_STEPS - 1)) state_d = ST_RSD;
			ST_RSD: state_d = red_last ? ST_RFIN : ST_RRD;
			ST_RFIN: state_d = (range_c == '0) ? ST_DONE : ST_DIV;
			ST_RQ: state_d = ST_DONE;
			ST_DONE: if (can_load) state_d = ST_IDLE;
			ST_DIV: if (div_cnt_q == DCNT_W'(DIV_W - 1)) state_d = div_ret_q;
			default: state_d = ST_IDLE;
		endcase
	end

	// state memory
	always_ff @(posedge clk) begin
		rd_q <= mem[k_q];
		if (state_q == ST_CWR) begin
			mem[k_q] <= {c_ws_new, c_active ? c_rs_new : e_rs_q,
				c_active ? c_ss_new : e_ss_q};
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			seen_q <= '0;
			vld_q <= '0;
			rvld_q <= 1'b0;
			div_ret_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_WINDOW; i++) rec_q[i] <= '0;
		end else begin
			rvld_q <= vld_q[k_q];
			if (state_q == ST_DONE && can_load) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (accept) k_q <= '0;
				ST_CMEAN: div_ret_q <= ST_CR;
				ST_CWR: begin
					vld_q[k_q] <= 1'b1;
					if (cell_last) begin
						k_q <= '0;
						seen_q <= seen_q + CNT_W'(1);
						for (int i = MAX_WINDOW - 1; i > 0; i--) rec_q[i] <= rec_q[i-1];
						rec_q[0] <= y_q;
					end else begin
						k_q <= k_q + K_W'(1);
					end
				end
				ST_RBEG: k_q <= '0;
				ST_RM: div_ret_q <= ST_RMSQ;
				ST_RMSQ: div_ret_q <= ST_RP;
				ST_RP: div_ret_q <= ST_RV;
				ST_RSD: if (!red_last) k_q <= k_q + K_W'(1);
				ST_RFIN: div_ret_q <= ST_RQ;
				ST_DONE: begin
					if (can_load) begin
						k_q <= '0;
						seen_q <= '0;
						vld_q <= '0;
						for (int i = 0; i < MAX_WINDOW; i++) rec_q[i] <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					y_q <= sample;
					last_q <= is_last;
				end
			end
			ST_CMEAN: begin
				e_ws_q <= rd_ws;
				e_rs_q <= rd_rs;
				e_ss_q <= rd_ss;
				ws_neg_q <= rd_ws[WS_W-1];
				div_quo_q <= rd_ws[WS_W-1] ? DIV_W'(-rd_ws) : DIV_W'(rd_ws);
				div_rem_q <= '0;
				div_den_q <= DIV_W'(k_q) + DIV_W'(1);
				div_cnt_q <= '0;
			end
			ST_CR: r_q <= c_r;
			ST_CMUL: prod_q <= 66'(c_abs[32:0]) * 66'(c_abs[32:0]);
			ST_RBEG: begin
				res_stat_q <= STAT_SHORT;
				res_feat_q <= '0;
			end
			ST_RM: begin
				e_ss_q <= rd_ss;
				div_quo_q <= DIV_W'(rs_abs);
				div_rem_q <= '0;
				div_den_q <= DIV_W'(n_c);
				div_cnt_q <= '0;
			end
			ST_RMSQ: begin
				msq_q <= {16'd0, am_sq[63:16]};
				div_quo_q <= e_ss_q;
				div_rem_q <= '0;
				div_den_q <= DIV_W'(n_c);
				div_cnt_q <= '0;
			end
			ST_RP: begin
				p_q <= p_c;
				div_quo_q <= p_c;
				div_rem_q <= '0;
				div_den_q <= DIV_W'(n_c) - DIV_W'(1);
				div_cnt_q <= '0;
			end
			ST_RV: begin
				sq_v_q <= {vs_c[47:0], 16'd0};
				sq_res_q <= '0;
				sq_bit_q <= 64'd1 << 62;
				sq_cnt_q <= '0;
			end
			ST_SQRT: begin
				if (sq_ge) begin
					sq_v_q <= sq_v_q - sq_t;
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
				sq_cnt_q <= sq_cnt_q + 5'd1;
			end
			ST_RSD: begin
				lastsd_q <= sd_c;
				if (k_q == '0) begin
					lo_q <= sd_c;
					hi_q <= sd_c;
					first_q <= sd_c;
				end else begin
					if (sd_c < lo_q) lo_q <= sd_c;
					if (sd_c > hi_q) hi_q <= sd_c;
				end
			end
			ST_RFIN: begin
				res_stat_q <= STAT_FLAT;
				res_feat_q <= '0;
				neg_q <= lastsd_q < first_q;
				div_quo_q <= DIV_W'({mag_c, {FEAT_FRAC{1'b0}}});
				div_rem_q <= '0;
				div_den_q <= fden_c;
				div_cnt_q <= '0;
			end
			ST_RQ: begin
				res_stat_q <= STAT_OK;
				res_feat_q <= neg_q ? -$signed(div_quo_q[31:0]) : $signed(div_quo_q[31:0]);
			end
			ST_DONE: begin
				if (can_load) begin
					feature_q <= res_feat_q;
					status_q <= res_stat_q;
				end
			end
			ST_DIV: begin
				div_rem_q <= dv_rem_n;
				div_quo_q <= {div_quo_q[DIV_W-2:0], dv_ge};
				div_cnt_q <= div_cnt_q + DCNT_W'(1);
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign feature = feature_q;
	assign status = status_q;

	`LMFET_ASSERT_IMPL(a_flag_zero, out_valid && status != STAT_OK, feature == 0, "feature not zero with status set")
	`LMFET_ASSERT_IMPL(a_status_code, out_valid, status == STAT_OK || status == STAT_SHORT || status == STAT_FLAT, "bad status code")
	`LMFET_ASSERT_NEXT(a_count_step, state_q == ST_CWR && cell_last, seen_q == $past(seen_q) + CNT_W'(1), "sample count did not advance")
	`LMFET_ASSERT_NEXT(a_clear_done, state_q == ST_DONE && can_load, seen_q == '0 && vld_q == '0 && out_valid, "state not cleared after result")
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// self-checking testbench for the local mean forecast error trend block
`default_nettype none
module tb;
	import lmfet_pkg::*;

	localparam int WIN = 10;
	localparam int SAMPLE_LIMIT = 65536;
	localparam int MIN_SERIES = WIN + 2;
	localparam int DRAIN_CYCLES = 3000;
	localparam int HOLD_CYCLES = 30000;
	localparam int ITEMS_PER_PHASE = 560;
	localparam longint RSUM_HI = longint'(64'h007F_FFFF_FFFF_FFFF);
	localparam longint RSUM_LO = -RSUM_HI - 1;

	typedef struct {
		logic signed [31:0] value;
		bit                 last;
		bit                 typed;
		logic signed [31:0] feature_exp;
		status_t            status_exp;
	} stim_row_t;

	typedef struct {
		logic signed [31:0] feature;
		status_t            status;
	} trend_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] sample;
	logic               is_last;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] feature;
	status_t            status;

	local_mean_forecast_error_trend_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample), .is_last(is_last),
		.out_valid(out_valid), .out_stall(out_stall), .feature(feature), .status(status)
	);

	// predictor state
	longint      recent_val[WIN];
	longint      win_sum[WIN];
	longint      resid_sum[WIN];
	bit [63:0]   resid_sq_sum[WIN];
	int unsigned seen_cnt;

	trend_t      trend_q[$];
	stim_row_t   dir_rows[$];
	int          mismatches;
	int          tx_idle_pct;
	int          rx_idle_pct;
	bit          hold_start;
	int          hold_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#200000000;
		$display("tb failed");
		$finish;
	end

	function automatic void clear_series();
		for (int k = 0; k < WIN; k++) begin
			recent_val[k] = 0;
			win_sum[k] = 0;
			resid_sum[k] = 0;
			resid_sq_sum[k] = 0;
		end
		seen_cnt = 0;
	endfunction

	function automatic bit [63:0] int_sqrt(bit [63:0] v);
		bit [63:0] res;
		bit [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic bit [63:0] window_dev(int len, longint total);
		longint    n;
		longint    m;
		bit [63:0] nu;
		bit [63:0] am;
		bit [63:0] msq;
		bit [63:0] q;
		bit [63:0] p;
		bit [63:0] v;
		n = total - len;
		nu = n;
		m = resid_sum[len-1] / n;
		am = (m < 0) ? -m : m;
		if (am > 64'hFFFF_FFFF)
			am = 64'hFFFF_FFFF;
		msq = (am * am) >> 16;
		q = resid_sq_sum[len-1] / nu;
		p = (q > msq) ? q - msq : 64'd0;
		v = p + p / (nu - 64'd1);
		if (v > VAR_MAX)
			v = VAR_MAX;
		return int_sqrt(v << 16);
	endfunction

	function automatic bit forecast_step(logic signed [31:0] s, bit last, output trend_t res);
		longint    y;
		longint    r;
		longint    acc;
		bit [63:0] ar;
		bit [63:0] sq;
		bit [63:0] sd[WIN];
		bit [63:0] lo;
		bit [63:0] hi;
		bit [63:0] mag;
		bit [63:0] qv;
		bit        neg;
		y = s;
		res.feature = 0;
		res.status = STAT_OK;
		if (seen_cnt < SAMPLE_LIMIT) begin
			for (int k = 0; k < WIN; k++) begin
				if (seen_cnt >= k + 1) begin
					r = win_sum[k] / longint'(k + 1) - y;
					ar = (r < 0) ? -r : r;
					sq = (ar * ar) >> 16;
					acc = resid_sum[k] + r;
					if (acc > RSUM_HI)
						acc = RSUM_HI;
					if (acc < RSUM_LO)
						acc = RSUM_LO;
					resid_sum[k] = acc;
					if (resid_sq_sum[k] > ~64'd0 - sq)
						resid_sq_sum[k] = ~64'd0;
					else
						resid_sq_sum[k] = resid_sq_sum[k] + sq;
				end
				win_sum[k] = win_sum[k] + y - recent_val[k];
			end
			for (int k = WIN - 1; k > 0; k--)
				recent_val[k] = recent_val[k-1];
			recent_val[0] = y;
			seen_cnt++;
		end
		if (!last)
			return 1'b0;
		if (seen_cnt < MIN_SERIES) begin
			res.status = STAT_SHORT;
		end else begin
			for (int k = 0; k < WIN; k++)
				sd[k] = window_dev(k + 1, longint'(seen_cnt));
			lo = sd[0];
			hi = sd[0];
			for (int k = 1; k < WIN; k++) begin
				if (sd[k] < lo)
					lo = sd[k];
				if (sd[k] > hi)
					hi = sd[k];
			end
			if (hi == lo) begin
				res.status = STAT_FLAT;
			end else begin
				neg = sd[WIN-1] < sd[0];
				mag = neg ? sd[0] - sd[WIN-1] : sd[WIN-1] - sd[0];
				qv = (mag << 30) / (64'(WIN - 1) * (hi - lo));
				if (neg)
					qv = -qv;
				res.feature = qv[31:0];
			end
		end
		clear_series();
		return 1'b1;
	endfunction

	task automatic offer(logic signed [31:0] s, bit last, bit typed, trend_t typed_res);
		trend_t res;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		is_last <= last;
		do @(posedge clk); while (in_stall);
		if (forecast_step(s, last, res))
			trend_q.push_back(typed ? typed_res : res);
	endtask

	function automatic logic signed [31:0] rand_value(int mode, int idx, logic signed [31:0] base);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(2097151)) - 32'sd1048576;
			2: return base;
			3: return base + idx * $signed($urandom_range(4095));
			default: return base + $signed($urandom_range(255)) - 32'sd128;
		endcase
	endfunction

	task automatic random_series(int len);
		trend_t             none;
		int                 mode;
		logic signed [31:0] base;
		none = '{0, STAT_OK};
		mode = $urandom_range(4);
		base = (mode == 2) ? $urandom : $signed($urandom_range(65535)) << ($urandom_range(14));
		for (int i = 0; i < len; i++)
			offer(rand_value(mode, i, base), i == len - 1, 1'b0, none);
	endtask

	function automatic int rand_len();
		int pick;
		pick = $urandom_range(99);
		if (pick < 15)
			return $urandom_range(MIN_SERIES - 1, 1);
		if (pick < 85)
			return $urandom_range(24, MIN_SERIES);
		return $urandom_range(50, 25);
	endfunction

	task automatic random_phase(int tx_pct, int rx_pct, bit with_hold);
		int sent;
		trend_t none;
		none = '{0, STAT_OK};
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		sent = 0;
		if (with_hold) begin
			hold_start = 1'b1;
			for (int i = 0; i < 3; i++)
				random_series(MIN_SERIES);
			sent = 3 * MIN_SERIES;
		end
		while (sent < ITEMS_PER_PHASE) begin
			int len;
			len = rand_len();
			if ($urandom_range(19) == 0) begin
				// noise: random values with a random end mark
				for (int i = 0; i < len; i++)
					offer($urandom, $urandom_range(9) == 0, 1'b0, none);
				offer($urandom, 1'b1, 1'b0, none);
				len++;
			end else begin
				random_series(len);
			end
			sent += len;
		end
		in_valid <= 1'b0;
		wait (trend_q.size() == 0);
		@(posedge clk);
	endtask

	// result checker and receiver stall
	always @(posedge clk) begin
		trend_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (trend_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transaction: feature %h status %0d", feature, status);
				end else begin
					e = trend_q.pop_front();
					if (feature !== e.feature || status !== e.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: feature exp %h got %h, status exp %0d got %0d",
								e.feature, feature, e.status, status);
					end
				end
			end
			if (hold_start) begin
				hold_left = HOLD_CYCLES;
				hold_start = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	initial begin
		trend_t tr;
		stim_row_t row;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		is_last = 1'b0;
		out_stall = 1'b0;
		mismatches = 0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_start = 1'b0;
		hold_left = 0;
		clear_series();

		// single sample series, then flat series at the top, then alternating extremes
		dir_rows.push_back('{32'sh8000_0000, 1'b1, 1'b1, 32'sd0, STAT_SHORT});
		for (int i = 0; i < MIN_SERIES; i++)
			dir_rows.push_back('{32'sh7FFF_FFFF, i == MIN_SERIES - 1, i == MIN_SERIES - 1,
				32'sd0, STAT_FLAT});
		for (int i = 0; i < MIN_SERIES; i++)
			dir_rows.push_back('{(i % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000,
				i == MIN_SERIES - 1, 1'b0, 32'sd0, STAT_OK});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			tr = '{row.feature_exp, row.status_exp};
			offer(row.value, row.last, row.typed, tr);
		end
		in_valid <= 1'b0;
		wait (trend_q.size() == 0);
		@(posedge clk);

		random_phase(34, 63, 1'b0);
		random_phase(63, 34, 1'b0);
		random_phase(0, 0, 1'b1);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && trend_q.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule
`default_nettype wire
